@@ src/oasf_pkg.sv @@
// Shared types, state codes, register indexes and constants for the obstacle steering block.
package oasf_pkg;

    localparam int DIST_W  = 8;
    localparam int COUNT_W = 16;
    localparam int SPEED_W = 12;
    localparam int RATE_W  = 12;
    localparam int CMD_W   = 13;
    localparam int STATE_W = 4;
    localparam int TICK_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // Decision thresholds and floor-turn length.
    localparam logic [DIST_W-1:0] STRAIGHT_LIMIT   = 8'd3;
    localparam logic [DIST_W-1:0] STOP_LIMIT       = 8'd0;
    localparam logic [TICK_W-1:0] FLOOR_TURN_TICKS = 2'd3;

    // Navigation state codes; these are also the reported action codes.
    localparam logic [STATE_W-1:0] ST_DECIDE   = 4'd0;
    localparam logic [STATE_W-1:0] ST_FLOOR_L  = 4'd1;
    localparam logic [STATE_W-1:0] ST_FLOOR_R  = 4'd2;
    localparam logic [STATE_W-1:0] ST_STOP_L   = 4'd3;
    localparam logic [STATE_W-1:0] ST_HARD_L   = 4'd4;
    localparam logic [STATE_W-1:0] ST_SOFT_L   = 4'd5;
    localparam logic [STATE_W-1:0] ST_STRAIGHT = 4'd6;
    localparam logic [STATE_W-1:0] ST_SOFT_R   = 4'd7;
    localparam logic [STATE_W-1:0] ST_HARD_R   = 4'd8;
    localparam logic [STATE_W-1:0] ST_STOP_R   = 4'd9;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [IDX_W-1:0] REG_FAST_SPEED      = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLOW_SPEED      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOFT_RATE       = 3'd2;
    localparam logic [IDX_W-1:0] REG_HARD_RATE       = 3'd3;
    localparam logic [IDX_W-1:0] REG_STOP_RATE       = 3'd4;
    localparam logic [IDX_W-1:0] REG_FLOOR_THRESHOLD = 3'd5;
    localparam logic [IDX_W-1:0] REG_SOFT_THRESHOLD  = 3'd6;
    localparam logic [IDX_W-1:0] REG_HARD_THRESHOLD  = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0] fast_speed;
        logic [SPEED_W-1:0] slow_speed;
        logic [RATE_W-1:0]  soft_rate;
        logic [RATE_W-1:0]  hard_rate;
        logic [RATE_W-1:0]  stop_rate;
        logic [COUNT_W-1:0] floor_threshold;
        logic [DIST_W-1:0]  soft_threshold;
        logic [DIST_W-1:0]  hard_threshold;
    } cfg_t;

endpackage

@@ src/oasf_cfg.sv @@
// Configuration register file behind the APB-style port.
module oasf_cfg
    import oasf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    logic [IDX_W-1:0] idx;
    logic             wr_en;
    cfg_t             cfg_reg;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_speed      <= 12'd512;
            cfg_reg.slow_speed      <= 12'd256;
            cfg_reg.soft_rate       <= 12'd402;
            cfg_reg.hard_rate       <= 12'd804;
            cfg_reg.stop_rate       <= 12'd1608;
            cfg_reg.floor_threshold <= 16'd800;
            cfg_reg.soft_threshold  <= 8'd2;
            cfg_reg.hard_threshold  <= 8'd1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FAST_SPEED:      cfg_reg.fast_speed      <= pwdata[SPEED_W-1:0];
                REG_SLOW_SPEED:      cfg_reg.slow_speed      <= pwdata[SPEED_W-1:0];
                REG_SOFT_RATE:       cfg_reg.soft_rate       <= pwdata[RATE_W-1:0];
                REG_HARD_RATE:       cfg_reg.hard_rate       <= pwdata[RATE_W-1:0];
                REG_STOP_RATE:       cfg_reg.stop_rate       <= pwdata[RATE_W-1:0];
                REG_FLOOR_THRESHOLD: cfg_reg.floor_threshold <= pwdata[COUNT_W-1:0];
                REG_SOFT_THRESHOLD:  cfg_reg.soft_threshold  <= pwdata[DIST_W-1:0];
                REG_HARD_THRESHOLD:  cfg_reg.hard_threshold  <= pwdata[DIST_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FAST_SPEED:      prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_reg.fast_speed};
            REG_SLOW_SPEED:      prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_reg.slow_speed};
            REG_SOFT_RATE:       prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.soft_rate};
            REG_HARD_RATE:       prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.hard_rate};
            REG_STOP_RATE:       prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.stop_rate};
            REG_FLOOR_THRESHOLD: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_reg.floor_threshold};
            REG_SOFT_THRESHOLD:  prdata = {{(DATA_W-DIST_W){1'b0}}, cfg_reg.soft_threshold};
            REG_HARD_THRESHOLD:  prdata = {{(DATA_W-DIST_W){1'b0}}, cfg_reg.hard_threshold};
            default:             prdata = '0;
        endcase
    end

endmodule

@@ src/oasf_decide.sv @@
// Priority tree that picks the next action from the column distances and floor counts.
module oasf_decide
    import oasf_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [DIST_W-1:0]  c1,
    input  logic [DIST_W-1:0]  c2,
    input  logic [DIST_W-1:0]  c3,
    input  logic [DIST_W-1:0]  c4,
    input  logic [DIST_W-1:0]  c5,
    input  logic [DIST_W-1:0]  c6,
    input  logic [DIST_W-1:0]  c7,
    input  logic [COUNT_W-1:0] floor_left,
    input  logic [COUNT_W-1:0] floor_right,
    output logic [STATE_W-1:0] next_state
);

    logic            right_of3;
    logic            left_of5;
    logic            any_open;
    logic [DIST_W+1:0] left_sum;
    logic [DIST_W+1:0] right_sum;

    assign right_of3 = (c4 > c3) && (c5 > c3);
    assign left_of5  = (c4 > c5) && (c3 > c5);
    assign any_open  = (c2 > STOP_LIMIT) || (c3 > STOP_LIMIT) || (c4 > STOP_LIMIT)
                    || (c5 > STOP_LIMIT) || (c6 > STOP_LIMIT);
    assign left_sum  = {2'b00, c1} + {2'b00, c2} + {2'b00, c3};
    assign right_sum = {2'b00, c5} + {2'b00, c6} + {2'b00, c7};

    always_comb
    begin
        if ((floor_left < cfg.floor_threshold) && (floor_left < floor_right))
            next_state = ST_FLOOR_R;
        else if (floor_right < cfg.floor_threshold)
            next_state = ST_FLOOR_L;
        else if ((c3 > STRAIGHT_LIMIT) && (c4 > STRAIGHT_LIMIT) && (c5 > STRAIGHT_LIMIT))
            next_state = ST_STRAIGHT;
        else if (c4 > cfg.soft_threshold)
            next_state = right_of3 ? ST_SOFT_R : ST_SOFT_L;
        else if ((c3 > cfg.soft_threshold) && right_of3)
            next_state = ST_SOFT_R;
        else if ((c5 > cfg.soft_threshold) && left_of5)
            next_state = ST_SOFT_L;
        else if (c4 > cfg.hard_threshold)
            next_state = right_of3 ? ST_HARD_R : ST_HARD_L;
        else if ((c3 > cfg.hard_threshold) && right_of3)
            next_state = ST_HARD_R;
        else if ((c5 > cfg.hard_threshold) && left_of5)
            next_state = ST_HARD_L;
        else if ((c2 > cfg.hard_threshold) && (c4 > c2) && (c5 > c2))
            next_state = ST_HARD_R;
        else if ((c6 > cfg.hard_threshold) && (c4 > c6) && (c3 > c6))
            next_state = ST_HARD_L;
        else if (any_open)
            next_state = (left_sum > right_sum) ? ST_STOP_L : ST_STOP_R;
        else
            next_state = ST_STOP_R;
    end

endmodule

@@ src/obstacle_avoid_steering_fsm_core.sv @@
// Top level of the obstacle-avoiding steering state machine.
//
//  Channel   Handshake               Payload
//  input     in_valid / in_stall     guided, dist_col1..dist_col7, floor_left_count,
//                                    floor_right_count
//  result    out_valid / out_stall   command_valid, speed_cmd, turn_rate_cmd, action
//  config    psel/penable/pwrite     paddr, pwdata, prdata (pready always high)
//
// One transaction is taken per cycle while the result is not stalled; an accepted input
// transaction passes through the input register, then the state update and result
// register, before its result is offered.
// Reset returns the state machine to decide with zero held speed and rate, and loads
// the register defaults. A stalled result holds the state update, the input register
// stays full and in_stall rises until the result is taken.
module obstacle_avoid_steering_fsm_core
    import oasf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     guided,
    input  logic [DIST_W-1:0]        dist_col1,
    input  logic [DIST_W-1:0]        dist_col2,
    input  logic [DIST_W-1:0]        dist_col3,
    input  logic [DIST_W-1:0]        dist_col4,
    input  logic [DIST_W-1:0]        dist_col5,
    input  logic [DIST_W-1:0]        dist_col6,
    input  logic [DIST_W-1:0]        dist_col7,
    input  logic [COUNT_W-1:0]       floor_left_count,
    input  logic [COUNT_W-1:0]       floor_right_count,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     command_valid,
    output logic [SPEED_W-1:0]       speed_cmd,
    output logic signed [CMD_W-1:0]  turn_rate_cmd,
    output logic [STATE_W-1:0]       action
);

    cfg_t cfg;

    // Input register stage.
    logic               in_valid_reg;
    logic               guided_reg;
    logic [DIST_W-1:0]  col1_reg, col2_reg, col3_reg, col4_reg, col5_reg, col6_reg, col7_reg;
    logic [COUNT_W-1:0] floor_left_reg, floor_right_reg;

    // Steering state.
    logic [STATE_W-1:0]     nav_state_reg, nav_state_next;
    logic [TICK_W-1:0]      floor_ticks_reg, floor_ticks_next;
    logic [SPEED_W-1:0]     held_speed_reg, held_speed_next;
    logic signed [CMD_W-1:0] held_rate_reg, held_rate_next;

    // Result register stage.
    logic                    out_valid_reg;
    logic                    cmd_valid_reg, cmd_valid_next;
    logic [SPEED_W-1:0]      speed_reg, speed_next;
    logic signed [CMD_W-1:0] rate_reg, rate_next;
    logic [STATE_W-1:0]      action_reg, action_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    fire;
    logic [STATE_W-1:0]      decided;
    logic signed [CMD_W-1:0] stop_pos, stop_neg, hard_pos, hard_neg, soft_pos, soft_neg;

    oasf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    oasf_decide u_decide (
        .cfg         (cfg),
        .c1          (col1_reg),
        .c2          (col2_reg),
        .c3          (col3_reg),
        .c4          (col4_reg),
        .c5          (col5_reg),
        .c6          (col6_reg),
        .c7          (col7_reg),
        .floor_left  (floor_left_reg),
        .floor_right (floor_right_reg),
        .next_state  (decided)
    );

    assign pready    = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign stop_pos = $signed({1'b0, cfg.stop_rate});
    assign hard_pos = $signed({1'b0, cfg.hard_rate});
    assign soft_pos = $signed({1'b0, cfg.soft_rate});
    assign stop_neg = -stop_pos;
    assign hard_neg = -hard_pos;
    assign soft_neg = -soft_pos;

    always_comb
    begin
        nav_state_next   = nav_state_reg;
        floor_ticks_next = floor_ticks_reg;
        held_speed_next  = held_speed_reg;
        held_rate_next   = held_rate_reg;
        action_next      = nav_state_reg;

        case (nav_state_reg)
            ST_FLOOR_L, ST_FLOOR_R:
            begin
                held_speed_next = '0;
                if (floor_ticks_reg == FLOOR_TURN_TICKS)
                begin
                    held_rate_next = '0;
                    nav_state_next = ST_DECIDE;
                end
                else
                begin
                    held_rate_next   = (nav_state_reg == ST_FLOOR_L) ? stop_neg : stop_pos;
                    floor_ticks_next = floor_ticks_reg + 2'd1;
                end
            end
            ST_STOP_L:
            begin
                held_speed_next = '0;
                held_rate_next  = stop_neg;
                nav_state_next  = ST_DECIDE;
            end
            ST_HARD_L:
            begin
                held_speed_next = cfg.slow_speed;
                held_rate_next  = hard_neg;
                nav_state_next  = ST_DECIDE;
            end
            ST_SOFT_L:
            begin
                held_speed_next = cfg.fast_speed;
                held_rate_next  = soft_neg;
                nav_state_next  = ST_DECIDE;
            end
            ST_STRAIGHT:
            begin
                held_speed_next = cfg.fast_speed;
                held_rate_next  = '0;
                nav_state_next  = ST_DECIDE;
            end
            ST_SOFT_R:
            begin
                held_speed_next = cfg.fast_speed;
                held_rate_next  = soft_pos;
                nav_state_next  = ST_DECIDE;
            end
            ST_HARD_R:
            begin
                held_speed_next = cfg.slow_speed;
                held_rate_next  = hard_pos;
                nav_state_next  = ST_DECIDE;
            end
            ST_STOP_R:
            begin
                held_speed_next = '0;
                held_rate_next  = stop_pos;
                nav_state_next  = ST_DECIDE;
            end
            default:
            begin
                // Decide re-issues what is held; unused codes behave the same way.
                action_next    = ST_DECIDE;
                nav_state_next = decided;
                if ((decided == ST_FLOOR_L) || (decided == ST_FLOOR_R))
                    floor_ticks_next = '0;
            end
        endcase

        cmd_valid_next = 1'b1;
        speed_next     = held_speed_next;
        rate_next      = held_rate_next;

        // Unguided ticks reset the state, issue an all-zero command; held values stay.
        if (!guided_reg)
        begin
            nav_state_next   = ST_DECIDE;
            floor_ticks_next = floor_ticks_reg;
            held_speed_next  = held_speed_reg;
            held_rate_next   = held_rate_reg;
            cmd_valid_next   = 1'b0;
            speed_next       = '0;
            rate_next        = '0;
            action_next      = ST_DECIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            nav_state_reg   <= ST_DECIDE;
            floor_ticks_reg <= '0;
            held_speed_reg  <= '0;
            held_rate_reg   <= '0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                nav_state_reg   <= nav_state_next;
                floor_ticks_reg <= floor_ticks_next;
                held_speed_reg  <= held_speed_next;
                held_rate_reg   <= held_rate_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            guided_reg      <= guided;
            col1_reg        <= dist_col1;
            col2_reg        <= dist_col2;
            col3_reg        <= dist_col3;
            col4_reg        <= dist_col4;
            col5_reg        <= dist_col5;
            col6_reg        <= dist_col6;
            col7_reg        <= dist_col7;
            floor_left_reg  <= floor_left_count;
            floor_right_reg <= floor_right_count;
        end
        if (fire)
        begin
            cmd_valid_reg <= cmd_valid_next;
            speed_reg     <= speed_next;
            rate_reg      <= rate_next;
            action_reg    <= action_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command_valid = cmd_valid_reg;
    assign speed_cmd     = speed_reg;
    assign turn_rate_cmd = rate_reg;
    assign action        = action_reg;

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cmd_valid_reg) |->
        (speed_reg == '0 && rate_reg == '0 && action_reg == ST_DECIDE))
        else $error("command without valid flag carries non-zero fields");

    a_ticks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        floor_ticks_reg <= FLOOR_TURN_TICKS)
        else $error("floor tick counter ran past the turn length");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        nav_state_reg <= ST_STOP_R)
        else $error("navigation state left the defined codes");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(nav_state_reg) && $stable(held_rate_reg)))
        else $error("state advanced while the result was stalled");

    a_action_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && guided_reg && nav_state_reg != ST_FLOOR_L && nav_state_reg != ST_FLOOR_R
         && nav_state_reg != ST_DECIDE) |=> (nav_state_reg == ST_DECIDE))
        else $error("action state did not return to decide");

endmodule

@@ tb/obstacle_avoid_steering_fsm_core_test.sv @@
// Self-checking testbench for the obstacle-avoiding steering state machine.
`timescale 1ns / 100ps

module obstacle_avoid_steering_fsm_core_test;
    import oasf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_TICKS    = 75;
    localparam int DIR_ROWS       = 23;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_mode_t;

    typedef struct packed {
        logic                      guided;
        logic [7:1][DIST_W-1:0]    col;
        logic [COUNT_W-1:0]        floor_left;
        logic [COUNT_W-1:0]        floor_right;
    } tick_t;

    typedef struct packed {
        logic                      cv;
        logic [SPEED_W-1:0]        speed;
        logic signed [CMD_W-1:0]   rate;
        logic [STATE_W-1:0]        act;
    } command_t;

    typedef struct packed {
        tick_t                     stim;
        logic                      has_exp;
        command_t                  exp;
    } steer_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic                     guided;
    logic [DIST_W-1:0]        dist_col1;
    logic [DIST_W-1:0]        dist_col2;
    logic [DIST_W-1:0]        dist_col3;
    logic [DIST_W-1:0]        dist_col4;
    logic [DIST_W-1:0]        dist_col5;
    logic [DIST_W-1:0]        dist_col6;
    logic [DIST_W-1:0]        dist_col7;
    logic [COUNT_W-1:0]       floor_left_count;
    logic [COUNT_W-1:0]       floor_right_count;
    logic                     out_valid;
    logic                     out_stall;
    logic                     command_valid;
    logic [SPEED_W-1:0]       speed_cmd;
    logic signed [CMD_W-1:0]  turn_rate_cmd;
    logic [STATE_W-1:0]       action;

    // Payload on offer, and an optional hand-written expectation that goes with it.
    tick_t       drv_tick;
    logic        drv_has_exp;
    command_t    drv_exp;

    // Mirror of the block's state and registers.
    logic [STATE_W-1:0]       nav_mirror;
    logic [TICK_W-1:0]        ticks_mirror;
    logic [SPEED_W-1:0]       speed_mirror;
    logic signed [CMD_W-1:0]  rate_mirror;
    cfg_t                     cfg_mirror;

    command_t    pending_cmds[$];
    int          mismatch_count = 0;
    int          commands_taken = 0;
    int          quiet_cycles   = 0;
    bit          squeeze_done   = 0;
    idle_mode_t  idle_mode      = IDLE_FULL;

    assign guided            = drv_tick.guided;
    assign dist_col1         = drv_tick.col[1];
    assign dist_col2         = drv_tick.col[2];
    assign dist_col3         = drv_tick.col[3];
    assign dist_col4         = drv_tick.col[4];
    assign dist_col5         = drv_tick.col[5];
    assign dist_col6         = drv_tick.col[6];
    assign dist_col7         = drv_tick.col[7];
    assign floor_left_count  = drv_tick.floor_left;
    assign floor_right_count = drv_tick.floor_right;

    obstacle_avoid_steering_fsm_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .guided            (guided),
        .dist_col1         (dist_col1),
        .dist_col2         (dist_col2),
        .dist_col3         (dist_col3),
        .dist_col4         (dist_col4),
        .dist_col5         (dist_col5),
        .dist_col6         (dist_col6),
        .dist_col7         (dist_col7),
        .floor_left_count  (floor_left_count),
        .floor_right_count (floor_right_count),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .command_valid     (command_valid),
        .speed_cmd         (speed_cmd),
        .turn_rate_cmd     (turn_rate_cmd),
        .action            (action)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [CMD_W-1:0] signed_rate(logic [RATE_W-1:0] mag, bit left);
        logic signed [CMD_W-1:0] r;
        r = $signed({1'b0, mag});
        return left ? -r : r;
    endfunction

    function automatic void hold_command(logic [SPEED_W-1:0] speed,
                                         logic signed [CMD_W-1:0] rate);
        speed_mirror = speed;
        rate_mirror  = rate;
        nav_mirror   = ST_DECIDE;
    endfunction

    // Priority tree run in the decide state: floor turns, straight, then soft, hard, stop.
    function automatic logic [STATE_W-1:0] pick_manoeuvre(tick_t t);
        int c [1:7];
        int gl, gr, st, ht, sl, sp;
        bit r3;
        for (int i = 1; i <= 7; i++)
            c[i] = t.col[i];
        gl = t.floor_left;
        gr = t.floor_right;
        st = cfg_mirror.soft_threshold;
        ht = cfg_mirror.hard_threshold;
        sl = STRAIGHT_LIMIT;
        sp = STOP_LIMIT;
        r3 = (c[4] > c[3]) && (c[5] > c[3]);
        if (gl < cfg_mirror.floor_threshold && gl < gr)
        begin
            ticks_mirror = '0;
            return ST_FLOOR_R;
        end
        if (gr < cfg_mirror.floor_threshold)
        begin
            ticks_mirror = '0;
            return ST_FLOOR_L;
        end
        if (c[3] > sl && c[4] > sl && c[5] > sl) return ST_STRAIGHT;
        if (c[4] > st) return r3 ? ST_SOFT_R : ST_SOFT_L;
        if (c[3] > st && r3) return ST_SOFT_R;
        if (c[5] > st && c[4] > c[5] && c[3] > c[5]) return ST_SOFT_L;
        if (c[4] > ht) return r3 ? ST_HARD_R : ST_HARD_L;
        if (c[3] > ht && r3) return ST_HARD_R;
        if (c[5] > ht && c[4] > c[5] && c[3] > c[5]) return ST_HARD_L;
        if (c[2] > ht && c[4] > c[2] && c[5] > c[2]) return ST_HARD_R;
        if (c[6] > ht && c[4] > c[6] && c[3] > c[6]) return ST_HARD_L;
        if (c[2] > sp || c[3] > sp || c[4] > sp || c[5] > sp || c[6] > sp)
            return ((c[1] + c[2] + c[3]) > (c[5] + c[6] + c[7])) ? ST_STOP_L : ST_STOP_R;
        return ST_STOP_R;
    endfunction

    // Advances the mirrored state by one tick and returns the command it issues.
    function automatic command_t steer_step(tick_t t);
        command_t r;
        r = '0;
        if (!t.guided)
        begin
            nav_mirror = ST_DECIDE;
            return r;
        end
        r.act = nav_mirror;
        case (nav_mirror)
            ST_FLOOR_L, ST_FLOOR_R:
                if (ticks_mirror == FLOOR_TURN_TICKS)
                    hold_command('0, '0);
                else
                begin
                    speed_mirror = '0;
                    rate_mirror  = signed_rate(cfg_mirror.stop_rate, nav_mirror == ST_FLOOR_L);
                    ticks_mirror = ticks_mirror + 1'b1;
                end
            ST_STOP_L:   hold_command('0, signed_rate(cfg_mirror.stop_rate, 1));
            ST_HARD_L:   hold_command(cfg_mirror.slow_speed, signed_rate(cfg_mirror.hard_rate, 1));
            ST_SOFT_L:   hold_command(cfg_mirror.fast_speed, signed_rate(cfg_mirror.soft_rate, 1));
            ST_STRAIGHT: hold_command(cfg_mirror.fast_speed, '0);
            ST_SOFT_R:   hold_command(cfg_mirror.fast_speed, signed_rate(cfg_mirror.soft_rate, 0));
            ST_HARD_R:   hold_command(cfg_mirror.slow_speed, signed_rate(cfg_mirror.hard_rate, 0));
            ST_STOP_R:   hold_command('0, signed_rate(cfg_mirror.stop_rate, 0));
            default:
            begin
                r.act = ST_DECIDE;
                nav_mirror = pick_manoeuvre(t);
            end
        endcase
        r.cv    = 1'b1;
        r.speed = speed_mirror;
        r.rate  = rate_mirror;
        return r;
    endfunction

    function automatic int pick_wait();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_FULL:  return $urandom_range(0, 16);
            default:    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Distances cluster around the thresholds so that every branch of the tree is reached.
    function automatic logic [DIST_W-1:0] pick_dist();
        int sel, thr, lo, hi;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return DIST_W'($urandom_range(0, 255));
        if (sel < 6)
        begin
            thr = (sel < 4) ? cfg_mirror.soft_threshold : cfg_mirror.hard_threshold;
            lo = (thr > 0) ? thr - 1 : 0;
            hi = (thr < 255) ? thr + 1 : 255;
            return DIST_W'($urandom_range(lo, hi));
        end
        return DIST_W'($urandom_range(0, STRAIGHT_LIMIT + 2));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_floor();
        int sel, thr;
        sel = $urandom_range(0, 9);
        thr = cfg_mirror.floor_threshold;
        if (sel == 0)
            return COUNT_W'($urandom_range(0, 65535));
        if (sel < 3)
            return COUNT_W'((thr > 0) ? $urandom_range(0, thr - 1) : 0);
        return COUNT_W'($urandom_range(thr, 65535));
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.guided = ($urandom_range(0, 99) < 88);
        for (int i = 1; i <= 7; i++)
            t.col[i] = pick_dist();
        t.floor_left  = pick_floor();
        t.floor_right = pick_floor();
        return t;
    endfunction

    function automatic steer_row_t mk_row(bit g, int c1, int c2, int c3, int c4, int c5,
                                          int c6, int c7, int fl, int fr, bit he,
                                          bit cv, int sp, int rt, logic [STATE_W-1:0] ac);
        steer_row_t r;
        r.stim.guided      = g;
        r.stim.col         = {DIST_W'(c7), DIST_W'(c6), DIST_W'(c5), DIST_W'(c4),
                              DIST_W'(c3), DIST_W'(c2), DIST_W'(c1)};
        r.stim.floor_left  = COUNT_W'(fl);
        r.stim.floor_right = COUNT_W'(fr);
        r.has_exp          = he;
        r.exp.cv           = cv;
        r.exp.speed        = SPEED_W'(sp);
        r.exp.rate         = CMD_W'(rt);
        r.exp.act          = ac;
        return r;
    endfunction

    // Offers one tick; called and returns at a falling edge.
    task automatic drive_tick(tick_t t, logic he, command_t e);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        drv_tick    = t;
        drv_has_exp = he;
        drv_exp     = e;
        in_valid    = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = ($urandom & 32'hFFFF_0000) | value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Checker, register mirror and watchdog.
    always @(posedge clk)
    begin
        command_t got, want;
        bit busy;
        busy = 0;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                busy = 1;
                case (paddr[2 +: IDX_W])
                    REG_FAST_SPEED:      cfg_mirror.fast_speed      = pwdata[SPEED_W-1:0];
                    REG_SLOW_SPEED:      cfg_mirror.slow_speed      = pwdata[SPEED_W-1:0];
                    REG_SOFT_RATE:       cfg_mirror.soft_rate       = pwdata[RATE_W-1:0];
                    REG_HARD_RATE:       cfg_mirror.hard_rate       = pwdata[RATE_W-1:0];
                    REG_STOP_RATE:       cfg_mirror.stop_rate       = pwdata[RATE_W-1:0];
                    REG_FLOOR_THRESHOLD: cfg_mirror.floor_threshold = pwdata[COUNT_W-1:0];
                    REG_SOFT_THRESHOLD:  cfg_mirror.soft_threshold  = pwdata[DIST_W-1:0];
                    REG_HARD_THRESHOLD:  cfg_mirror.hard_threshold  = pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end
            // Results are checked before the new transaction is queued: a result always
            // belongs to an earlier tick.
            if (out_valid && !out_stall)
            begin
                busy = 1;
                commands_taken++;
                got = {command_valid, speed_cmd, turn_rate_cmd, action};
                if (pending_cmds.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected command: expected none, actual cv=%0b speed=%0d rate=%0d action=%0d",
                             $time, got.cv, got.speed, got.rate, got.act);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (got.cv !== want.cv || got.speed !== want.speed ||
                        got.rate !== want.rate || got.act !== want.act)
                    begin
                        mismatch_count++;
                        $display("%0t: expected cv=%0b speed=%0d rate=%0d action=%0d, actual cv=%0b speed=%0d rate=%0d action=%0d",
                                 $time, want.cv, want.speed, want.rate, want.act,
                                 got.cv, got.speed, got.rate, got.act);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                busy = 1;
                want = steer_step(drv_tick);
                if (drv_has_exp)
                    want = drv_exp;
                pending_cmds.push_back(want);
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d commands outstanding",
                         $time, pending_cmds.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: random hold-off per transaction, and one long hold to fill the block.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!squeeze_done && commands_taken >= 250)
            begin
                squeeze_done = 1;
                out_stall = 1'b1;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            hold = pick_wait();
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        steer_row_t dir_tab [DIR_ROWS];
        cfg_t       phase_cfg;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        drv_tick    = '0;
        drv_has_exp = 1'b0;
        drv_exp     = '0;

        nav_mirror   = ST_DECIDE;
        ticks_mirror = '0;
        speed_mirror = '0;
        rate_mirror  = '0;
        cfg_mirror.fast_speed      = 12'd512;
        cfg_mirror.slow_speed      = 12'd256;
        cfg_mirror.soft_rate       = 12'd402;
        cfg_mirror.hard_rate       = 12'd804;
        cfg_mirror.stop_rate       = 12'd1608;
        cfg_mirror.floor_threshold = 16'd800;
        cfg_mirror.soft_threshold  = 8'd2;
        cfg_mirror.hard_threshold  = 8'd1;

        // Not guided with every field at its maximum, then the first guided decide tick.
        dir_tab[0]  = mk_row(0, 255, 255, 255, 255, 255, 255, 255, 65535, 65535,
                             1, 0, 0, 0, ST_DECIDE);
        dir_tab[1]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 65535, 65535, 1, 1, 0, 0, ST_DECIDE);
        dir_tab[2]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 65535, 65535, 1, 1, 0, 1608, ST_STOP_R);
        dir_tab[3]  = mk_row(1, 10, 10, 10, 10, 10, 10, 10, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[4]  = mk_row(1, 10, 10, 10, 10, 10, 10, 10, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        // A full right floor turn: three ticks at the stop rate, then the end tick.
        dir_tab[5]  = mk_row(1, 10, 10, 10, 10, 10, 10, 10, 0, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[6]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[7]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[8]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[9]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_DECIDE);
        // Left floor turn broken off by a tick outside guided mode.
        dir_tab[10] = mk_row(1, 10, 10, 10, 10, 10, 10, 10, 900, 100, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[11] = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 900, 100, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[12] = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 900, 100, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[13] = mk_row(1, 0, 0, 6, 5, 1, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[14] = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[15] = mk_row(1, 0, 0, 0, 5, 5, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[16] = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[17] = mk_row(1, 0, 0, 0, 2, 2, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[18] = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[19] = mk_row(1, 255, 1, 0, 0, 0, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[20] = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 1000, 1000, 0, 0, 0, 0, ST_DECIDE);
        // Equal floor counts below the threshold pick the left floor turn.
        dir_tab[21] = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 500, 500, 0, 0, 0, 0, ST_DECIDE);
        dir_tab[22] = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_DECIDE);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        idle_mode = IDLE_FULL;
        for (int i = 0; i < DIR_ROWS; i++)
            drive_tick(dir_tab[i].stim, dir_tab[i].has_exp, dir_tab[i].exp);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    phase_cfg.fast_speed      = 12'd512;
                    phase_cfg.slow_speed      = 12'd256;
                    phase_cfg.soft_rate       = 12'd402;
                    phase_cfg.hard_rate       = 12'd804;
                    phase_cfg.stop_rate       = 12'd1608;
                    phase_cfg.floor_threshold = 16'd800;
                    phase_cfg.soft_threshold  = 8'd2;
                    phase_cfg.hard_threshold  = 8'd1;
                end
                1:  phase_cfg = '1;
                2:  phase_cfg = '0;
                default:
                begin
                    phase_cfg.fast_speed      = SPEED_W'($urandom_range(0, 4095));
                    phase_cfg.slow_speed      = SPEED_W'($urandom_range(0, 4095));
                    phase_cfg.soft_rate       = RATE_W'($urandom_range(0, 4095));
                    phase_cfg.hard_rate       = RATE_W'($urandom_range(0, 4095));
                    phase_cfg.stop_rate       = RATE_W'($urandom_range(0, 4095));
                    phase_cfg.floor_threshold = COUNT_W'((ph == 3) ? $urandom_range(0, 65535)
                                                                   : $urandom_range(0, 2000));
                    phase_cfg.soft_threshold  = DIST_W'((ph == 3) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 8));
                    phase_cfg.hard_threshold  = DIST_W'((ph == 3) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 8));
                end
            endcase
            cfg_write(REG_FAST_SPEED,      DATA_W'(phase_cfg.fast_speed));
            cfg_write(REG_SLOW_SPEED,      DATA_W'(phase_cfg.slow_speed));
            cfg_write(REG_SOFT_RATE,       DATA_W'(phase_cfg.soft_rate));
            cfg_write(REG_HARD_RATE,       DATA_W'(phase_cfg.hard_rate));
            cfg_write(REG_STOP_RATE,       DATA_W'(phase_cfg.stop_rate));
            cfg_write(REG_FLOOR_THRESHOLD, DATA_W'(phase_cfg.floor_threshold));
            cfg_write(REG_SOFT_THRESHOLD,  DATA_W'(phase_cfg.soft_threshold));
            cfg_write(REG_HARD_THRESHOLD,  DATA_W'(phase_cfg.hard_threshold));
            case (ph % 3)
                0:       idle_mode = IDLE_NONE;
                1:       idle_mode = IDLE_FULL;
                default: idle_mode = IDLE_LIGHT;
            endcase
            repeat (PHASE_TICKS)
                drive_tick(random_tick(), 1'b0, '0);
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
